FILE: src/dmqi_pkg.sv
// dmqi_pkg: shared constants, types and arithmetic helpers for the
// 8-point DCT / mask / quantize / inverse DCT core. No dependencies.
`timescale 1ns / 1ps

package dmqi_pkg;

  localparam int POINTS     = 8;
  localparam int IDX_W      = 3;
  localparam int SAMPLE_W   = 8;
  localparam int COEF_W     = 11;
  localparam int LEVEL_W    = 9;
  localparam int COS_W      = 16;
  localparam int VAL_W      = 12;
  localparam int PROD_W     = 28;
  localparam int ACC_W      = 30;
  localparam int RECIP_W    = 16;
  localparam int RECIP_SH   = 17;
  localparam int STEP_W     = 5;
  localparam int BLOCK_W    = POINTS * SAMPLE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int ROUND_SH   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT = 2'd1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FWD,
    B_QNT,
    B_QMB,
    B_INV,
    B_RND
  } back_state_t;

  // cos((2x+1)u pi/16) in Q14, orthonormal row 0 at 1/sqrt2
  function automatic logic signed [COS_W-1:0] cos_coef(logic [IDX_W-1:0] u,
                                                       logic [IDX_W-1:0] x);
    logic [6:0]  prod;
    logic [4:0]  p;
    logic [3:0]  m;
    logic        neg;
    logic [14:0] mag;
    prod = {3'b000, x, 1'b1} * {4'b0000, u};
    p    = prod[4:0];
    neg  = 1'b0;
    if (p <= 5'd8) begin
      m = p[3:0];
    end else if (p <= 5'd16) begin
      m   = 4'(5'd16 - p);
      neg = 1'b1;
    end else if (p <= 5'd24) begin
      m   = 4'(p - 5'd16);
      neg = 1'b1;
    end else begin
      m = 4'(6'd32 - {1'b0, p});
    end
    case (m)
      4'd0:    mag = 15'd16384;
      4'd1:    mag = 15'd16069;
      4'd2:    mag = 15'd15137;
      4'd3:    mag = 15'd13623;
      4'd4:    mag = 15'd11585;
      4'd5:    mag = 15'd9102;
      4'd6:    mag = 15'd6270;
      4'd7:    mag = 15'd3196;
      default: mag = 15'd0;
    endcase
    if (u == '0) begin
      mag = 15'd11585;
    end
    cos_coef = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // scale by sqrt(2/8) = 1/2, drop Q14, round half away, saturate
  function automatic logic signed [COEF_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic             neg;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [14:0]      r;
    neg = acc[ACC_W-1];
    mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
    sum = mag + ACC_W'(1 << (ROUND_SH - 1));
    r   = sum[ACC_W-1:ROUND_SH];
    if (neg) begin
      round_sat = (r > 15'd1024) ? -11'sd1024 : $signed(~r[COEF_W-1:0] + 11'd1);
    end else begin
      round_sat = (r > 15'd1023) ? 11'sd1023 : $signed(r[COEF_W-1:0]);
    end
  endfunction

  function automatic logic [STEP_W-1:0] quant_step(logic [IDX_W-1:0] u);
    quant_step = {1'b0, u, 1'b0} + 5'd3;
  endfunction

  // ceil(2^17 / step); exact truncating divide for magnitudes up to 1024
  function automatic logic [RECIP_W-1:0] quant_recip(logic [IDX_W-1:0] u);
    case (u)
      3'd0:    quant_recip = 16'd43691;
      3'd1:    quant_recip = 16'd26215;
      3'd2:    quant_recip = 16'd18725;
      3'd3:    quant_recip = 16'd14564;
      3'd4:    quant_recip = 16'd11916;
      3'd5:    quant_recip = 16'd10083;
      3'd6:    quant_recip = 16'd8739;
      default: quant_recip = 16'd7711;
    endcase
  endfunction

endpackage

FILE: src/dmqi_front.sv
// dmqi_front: sample loader, gathers eight samples into one block beat.
// Depends on dmqi_pkg.
`timescale 1ns / 1ps

module dmqi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dmqi_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [dmqi_pkg::BLOCK_W-1:0]      q_block
);

  logic [dmqi_pkg::IDX_W-1:0]    count_r;
  logic [dmqi_pkg::IDX_W-1:0]    count_nxt;
  logic [dmqi_pkg::SAMPLE_W-1:0] samples_r [dmqi_pkg::POINTS];
  logic                          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (count_r == 3'(dmqi_pkg::POINTS - 1));

  always_comb begin
    count_nxt = accept ? count_r + 3'd1 : count_r;
    for (int i = 0; i < dmqi_pkg::POINTS; i++) begin
      q_block[i*dmqi_pkg::SAMPLE_W +: dmqi_pkg::SAMPLE_W] =
        (i == dmqi_pkg::POINTS - 1) ? in_sample : samples_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samples_r[count_r] <= in_sample;
    end
  end

endmodule

FILE: src/dmqi_fifo.sv
// dmqi_fifo: two-entry block queue between loader and transform engine.
// Depends on dmqi_pkg.
`timescale 1ns / 1ps

module dmqi_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [dmqi_pkg::BLOCK_W-1:0]  wr_data,
  input  logic                          pop,
  output logic [dmqi_pkg::BLOCK_W-1:0]  rd_data,
  output logic                          full,
  output logic                          empty
);

  logic [dmqi_pkg::BLOCK_W-1:0] mem_r [2];
  logic                         wr_ptr_r;
  logic                         wr_ptr_nxt;
  logic                         rd_ptr_r;
  logic                         rd_ptr_nxt;
  logic [1:0]                   cnt_r;
  logic [1:0]                   cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("block pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("block popped from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

FILE: src/dmqi_back.sv
// dmqi_back: shared-MAC engine, forward DCT, mask, quantize, inverse DCT,
// and the result output register. Depends on dmqi_pkg.
`timescale 1ns / 1ps

module dmqi_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [dmqi_pkg::BLOCK_W-1:0]         q_data,
  output logic                                 q_pop,
  input  logic [dmqi_pkg::POINTS-1:0]          mask,
  input  logic                                 quant_en,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dmqi_pkg::IDX_W-1:0]           out_position,
  output logic signed [dmqi_pkg::COEF_W-1:0]   out_coefficient,
  output logic signed [dmqi_pkg::LEVEL_W-1:0]  out_quant_level,
  output logic signed [dmqi_pkg::COEF_W-1:0]   out_reconstructed,
  output logic                                 out_last
);

  localparam logic [dmqi_pkg::IDX_W-1:0] LAST_IDX = 3'(dmqi_pkg::POINTS - 1);

  dmqi_pkg::back_state_t              state_r, state_nxt;
  logic [dmqi_pkg::IDX_W-1:0]         u_r, u_nxt;
  logic [dmqi_pkg::IDX_W-1:0]         x_r, x_nxt;
  logic signed [dmqi_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [dmqi_pkg::BLOCK_W-1:0]       blk_r;
  logic signed [dmqi_pkg::COEF_W-1:0] c_r   [dmqi_pkg::POINTS];
  logic signed [dmqi_pkg::LEVEL_W-1:0] lvl_r [dmqi_pkg::POINTS];
  logic signed [dmqi_pkg::VAL_W-1:0]  v_r   [dmqi_pkg::POINTS];
  logic                               out_valid_r, out_valid_nxt;

  logic [dmqi_pkg::SAMPLE_W-1:0]      samp;
  logic signed [dmqi_pkg::COS_W-1:0]  cos_w;
  logic signed [24:0]                 fwd_prod;
  logic signed [dmqi_pkg::PROD_W-1:0] inv_prod;
  logic signed [dmqi_pkg::PROD_W-1:0] mac_prod;
  logic signed [dmqi_pkg::ACC_W-1:0]  mac_sum;
  logic signed [dmqi_pkg::COEF_W-1:0] c_raw, c_m;
  logic                               c_neg;
  logic [dmqi_pkg::COEF_W-1:0]        c_mag;
  logic [26:0]                        q_prod;
  logic [9:0]                         q;
  logic signed [dmqi_pkg::LEVEL_W-1:0] lvl_new;
  logic signed [14:0]                 v_prod;
  logic signed [dmqi_pkg::VAL_W-1:0]  v_new;
  logic                               load_blk, c_we, v_we, out_load;

  assign samp     = blk_r[{x_r, 3'b000} +: dmqi_pkg::SAMPLE_W];
  assign cos_w    = dmqi_pkg::cos_coef(u_r, x_r);
  assign fwd_prod = cos_w * $signed({1'b0, samp});
  assign inv_prod = v_r[u_r] * cos_w;
  assign mac_prod = (state_r == dmqi_pkg::B_INV) ? inv_prod : dmqi_pkg::PROD_W'(fwd_prod);
  assign mac_sum  = acc_r + dmqi_pkg::ACC_W'(mac_prod);

  always_comb begin
    c_raw  = dmqi_pkg::round_sat(acc_r);
    c_m    = mask[u_r] ? c_raw : '0;
    c_neg  = c_m[dmqi_pkg::COEF_W-1];
    c_mag  = c_neg ? dmqi_pkg::COEF_W'(-c_m) : dmqi_pkg::COEF_W'(c_m);
    q_prod = {16'd0, c_mag} * {11'd0, dmqi_pkg::quant_recip(u_r)};
    q      = q_prod[26:dmqi_pkg::RECIP_SH];
    if (!quant_en) begin
      lvl_new = '0;
    end else if (c_neg) begin
      lvl_new = (q > 10'd256) ? -9'sd256 : $signed(~q[8:0] + 9'd1);
    end else begin
      lvl_new = (q > 10'd255) ? 9'sd255 : $signed(q[8:0]);
    end
    v_prod = lvl_r[u_r] * $signed({1'b0, dmqi_pkg::quant_step(u_r)});
    v_new  = quant_en ? dmqi_pkg::VAL_W'(v_prod) : dmqi_pkg::VAL_W'(c_r[u_r]);
  end

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    load_blk  = 1'b0;
    c_we      = 1'b0;
    v_we      = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      dmqi_pkg::B_IDLE: begin
        if (!q_empty) begin
          load_blk  = 1'b1;
          u_nxt     = '0;
          x_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = dmqi_pkg::B_FWD;
        end
      end
      dmqi_pkg::B_FWD: begin
        acc_nxt = mac_sum;
        x_nxt   = x_r + 3'd1;
        if (x_r == LAST_IDX) begin
          state_nxt = dmqi_pkg::B_QNT;
        end
      end
      dmqi_pkg::B_QNT: begin
        c_we      = 1'b1;
        state_nxt = dmqi_pkg::B_QMB;
      end
      dmqi_pkg::B_QMB: begin
        v_we    = 1'b1;
        acc_nxt = '0;
        x_nxt   = '0;
        u_nxt   = u_r + 3'd1;
        if (u_r == LAST_IDX) begin
          state_nxt = dmqi_pkg::B_INV;
        end else begin
          state_nxt = dmqi_pkg::B_FWD;
        end
      end
      dmqi_pkg::B_INV: begin
        acc_nxt = mac_sum;
        u_nxt   = u_r + 3'd1;
        if (u_r == LAST_IDX) begin
          state_nxt = dmqi_pkg::B_RND;
        end
      end
      dmqi_pkg::B_RND: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          acc_nxt  = '0;
          u_nxt    = '0;
          x_nxt    = x_r + 3'd1;
          if (x_r == LAST_IDX) begin
            state_nxt = dmqi_pkg::B_IDLE;
          end else begin
            state_nxt = dmqi_pkg::B_INV;
          end
        end
      end
      default: begin
        state_nxt = dmqi_pkg::B_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  assign q_pop     = load_blk;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmqi_pkg::B_IDLE;
      u_r         <= '0;
      x_r         <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      u_r         <= u_nxt;
      x_r         <= x_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_blk) begin
      blk_r <= q_data;
    end
    if (c_we) begin
      c_r[u_r]   <= c_m;
      lvl_r[u_r] <= lvl_new;
    end
    if (v_we) begin
      v_r[u_r] <= v_new;
    end
    if (out_load) begin
      out_position      <= x_r;
      out_coefficient   <= c_r[x_r];
      out_quant_level   <= lvl_r[x_r];
      out_reconstructed <= dmqi_pkg::round_sat(acc_r);
      out_last          <= (x_r == LAST_IDX);
    end
  end

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last == (out_position == LAST_IDX)))
    else $error("last flag out of step with position");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == dmqi_pkg::B_IDLE))
    else $error("block taken while engine busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("stalled result overwritten");

endmodule

FILE: src/dct8_mask_quant_idct_core.sv
// Throughput is set by the single shared multiply-accumulate in the back end,
// which takes a new 8-sample block only after loading the last result of the one before.
// The loader takes samples every cycle while the two-block queue has room.
// Synchronous active-low reset clears counters, queue, engine state and sets
// the mask to all ones and quantization off.
`timescale 1ns / 1ps

module dct8_mask_quant_idct_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dmqi_pkg::SAMPLE_W-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dmqi_pkg::IDX_W-1:0]           out_position,
  output logic signed [dmqi_pkg::COEF_W-1:0]   out_coefficient,
  output logic signed [dmqi_pkg::LEVEL_W-1:0]  out_quant_level,
  output logic signed [dmqi_pkg::COEF_W-1:0]   out_reconstructed,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [dmqi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmqi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [dmqi_pkg::POINTS-1:0]  mask_r, mask_nxt;
  logic                         quant_r, quant_nxt;
  logic                         q_push, q_pop, q_full, q_empty;
  logic [dmqi_pkg::BLOCK_W-1:0] q_wr, q_rd;

  always_comb begin
    mask_nxt  = mask_r;
    quant_nxt = quant_r;
    if (cfg_we && cfg_index == dmqi_pkg::REG_MASK) begin
      mask_nxt = cfg_data;
    end
    if (cfg_we && cfg_index == dmqi_pkg::REG_QUANT) begin
      quant_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '1;
      quant_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      quant_r <= quant_nxt;
    end
  end

  dmqi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_block  (q_wr)
  );

  dmqi_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  dmqi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rd),
    .q_pop            (q_pop),
    .mask             (mask_r),
    .quant_en         (quant_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_coefficient  (out_coefficient),
    .out_quant_level  (out_quant_level),
    .out_reconstructed(out_reconstructed),
    .out_last         (out_last)
  );

endmodule

FILE: tb/dct8_mask_quant_idct_checker.sv
// Checker for dct8_mask_quant_idct_core: tracks config writes and accepted samples,
// predicts the eight results of each completed block and compares every result beat.
// Depends on dmqi_pkg for widths and register indexes.
`timescale 1ns / 1ps

module dct8_mask_quant_idct_checker
  import dmqi_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [SAMPLE_W-1:0]        in_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [IDX_W-1:0]           out_position,
  input  logic signed [COEF_W-1:0]   out_coefficient,
  input  logic signed [LEVEL_W-1:0]  out_quant_level,
  input  logic signed [COEF_W-1:0]   out_reconstructed,
  input  logic                       out_last,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         pending,
  output int                         results_seen,
  output int                         errors
);

  typedef struct {
    logic [IDX_W-1:0]          position;
    logic signed [COEF_W-1:0]  coefficient;
    logic signed [LEVEL_W-1:0] quant_level;
    logic signed [COEF_W-1:0]  reconstructed;
    logic                      last;
  } dct_result_t;

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned INVSQRT2_Q30 = 64'd759250125;

  dct_result_t      expected_results[$];
  longint           cos_q14[POINTS][POINTS];
  longint unsigned  norm_q30;
  logic [7:0]       block_samples[POINTS];
  int               fill;
  logic [7:0]       mask_reg;
  logic             quant_reg;

  assign pending = expected_results.size();

  function automatic longint unsigned cos_series_q30(longint unsigned m);
    longint unsigned t, t2, term;
    longint          sum;
    t    = (PI_Q30 * m) / (2 * POINTS);
    t2   = (t * t) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v   -= res + bits;
        res  = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic int scale_round_sat(longint acc);
    longint unsigned mag, r;
    mag = (acc < 0) ? longint'(-acc) : longint'(acc);
    r   = (mag * norm_q30 + (64'd1 << 43)) >> 44;
    if (acc < 0) return (r > 1024) ? -1024 : -int'(r);
    return (r > 1023) ? 1023 : int'(r);
  endfunction

  initial begin
    longint unsigned p, m, mag;
    bit              neg;
    for (int u = 0; u < POINTS; u++) begin
      for (int x = 0; x < POINTS; x++) begin
        p   = ((2 * x + 1) * u) % (4 * POINTS);
        neg = 0;
        if (p <= POINTS) m = p;
        else if (p <= 2 * POINTS) begin m = 2 * POINTS - p; neg = 1; end
        else if (p <= 3 * POINTS) begin m = p - 2 * POINTS; neg = 1; end
        else m = 4 * POINTS - p;
        mag = (u == 0) ? INVSQRT2_Q30 : cos_series_q30(m);
        mag = (mag + (64'd1 << 15)) >> 16;
        cos_q14[u][x] = neg ? -longint'(mag) : longint'(mag);
      end
    end
    norm_q30 = int_sqrt((64'd1 << 61) / POINTS);
  end

  task automatic predict_block();
    int          coef[POINTS];
    int          level[POINTS];
    longint      recon_in[POINTS];
    longint      acc;
    int          step;
    dct_result_t r;
    for (int u = 0; u < POINTS; u++) begin
      acc = 0;
      for (int x = 0; x < POINTS; x++) acc += cos_q14[u][x] * longint'(block_samples[x]);
      coef[u] = mask_reg[u] ? scale_round_sat(acc) : 0;
      if (quant_reg) begin
        step     = 2 * u + 3;
        level[u] = coef[u] / step;
        if (level[u] > 255) level[u] = 255;
        if (level[u] < -256) level[u] = -256;
        recon_in[u] = longint'(level[u]) * step;
      end else begin
        level[u]    = 0;
        recon_in[u] = coef[u];
      end
    end
    for (int x = 0; x < POINTS; x++) begin
      acc = 0;
      for (int u = 0; u < POINTS; u++) acc += recon_in[u] * cos_q14[u][x];
      r.position      = IDX_W'(x);
      r.coefficient   = COEF_W'(coef[x]);
      r.quant_level   = LEVEL_W'(level[x]);
      r.reconstructed = COEF_W'(scale_round_sat(acc));
      r.last          = (x == POINTS - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors       = 0;
    results_seen = 0;
    fill         = 0;
    mask_reg     = 8'hFF;
    quant_reg    = 1'b0;
  end

  always @(posedge clk) begin
    dct_result_t want;
    if (!rst_n) begin
      fill      <= 0;
      mask_reg  <= 8'hFF;
      quant_reg <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MASK:  mask_reg  <= cfg_data;
          REG_QUANT: quant_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        block_samples[fill] = in_sample;
        if (fill == POINTS - 1) begin
          predict_block();
          fill <= 0;
        end else begin
          fill <= fill + 1;
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, position", out_position, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_position !== want.position)
            report_mismatch("position", out_position, want.position);
          if (out_coefficient !== want.coefficient)
            report_mismatch("coefficient", out_coefficient, want.coefficient);
          if (out_quant_level !== want.quant_level)
            report_mismatch("quant_level", out_quant_level, want.quant_level);
          if (out_reconstructed !== want.reconstructed)
            report_mismatch("reconstructed", out_reconstructed, want.reconstructed);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
    end
  end

endmodule

FILE: tb/tb_dct8_mask_quant_idct_core.sv
// Top of the dct8_mask_quant_idct_core bench: clock, reset, sample and config stimulus,
// random back-pressure and the verdict. Depends on dmqi_pkg and the checker module.
`timescale 1ns / 1ps

module tb_dct8_mask_quant_idct_core;
  import dmqi_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_W-1:0]       in_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_position;
  logic signed [COEF_W-1:0]  out_coefficient;
  logic signed [LEVEL_W-1:0] out_quant_level;
  logic signed [COEF_W-1:0]  out_reconstructed;
  logic                      out_last;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  int pending, results_seen, errors;
  int blocks_sent = 0;
  int cfg_writes = 0;
  int hold_cycles = 0;
  bit quiet = 0;

  always #4 clk = ~clk;

  dct8_mask_quant_idct_core i_dut (.*);

  dct8_mask_quant_idct_checker i_checker (.*);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] val);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_block(logic [SAMPLE_W-1:0] s[POINTS]);
    foreach (s[i]) send_sample(s[i]);
    blocks_sent++;
  endtask

  task automatic send_random_block();
    logic [SAMPLE_W-1:0] s[POINTS];
    int                  style, base;
    style = $urandom_range(0, 3);
    base  = $urandom_range(0, 255);
    foreach (s[i]) begin
      case (style)
        0: s[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        1: s[i] = SAMPLE_W'(base + $urandom_range(0, 6) - 3);
        default: s[i] = SAMPLE_W'($urandom_range(0, 255));
      endcase
    end
    send_block(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // receiver back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] s[POINTS];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: flat extremes and an alternating full-swing block
    s = '{default: 8'h00};
    send_block(s);
    s = '{default: 8'hFF};
    send_block(s);
    foreach (s[i]) s[i] = i[0] ? 8'hFF : 8'h00;
    send_block(s);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_MASK, 8'hFF); write_reg(REG_QUANT, 8'h01); end
        1: begin write_reg(REG_MASK, 8'h00); write_reg(REG_QUANT, 8'h01); end
        2: begin write_reg(REG_MASK, 8'h01); write_reg(REG_QUANT, 8'h00); end
        3: begin write_reg(REG_MASK, 8'h80); write_reg(REG_QUANT, 8'hFF); end
        4: begin write_reg(REG_MASK, 8'h55); write_reg(REG_QUANT, 8'hFE); end
        default: begin
          write_reg(REG_MASK, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(REG_QUANT, CFG_DATA_W'($urandom_range(0, 255)));
        end
      endcase
      repeat (4) send_random_block();
      drain();
    end

    // long receiver hold while samples keep coming
    write_reg(REG_MASK, 8'hFF);
    write_reg(REG_QUANT, 8'h01);
    hold_cycles = 800;
    repeat (4) send_random_block();
    drain();

    // out-of-range indexes must be ignored; final stretch with no idling
    write_reg(2'd2, 8'h00);
    write_reg(2'd3, 8'h00);
    write_reg(REG_MASK, 8'hA5);
    quiet = 1;
    repeat (4) send_random_block();
    drain();

    $display("Covered %0d blocks (%0d result beats) across %0d register writes,",
             blocks_sent, results_seen, cfg_writes);
    $display("mask extremes, quantisation on/off, long output hold and idle-free tail.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
